// ===== sv/ssre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled sprite run emitter package
// Shared widths, codes, sequencer states and the run record type.
// ----------------------------------------------------------------------------
package ssre_pkg;

  localparam int unsigned CELL_W   = 8;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned COLOUR_W = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COL_W    = 5;

  // Bit of a stored row that holds the leftmost column.
  localparam logic [COL_W-1:0]  LEFT_COL   = 5'd31;
  localparam logic [CELL_W-1:0] CELL_RESET = 8'd26;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_ROW,
    ST_READ,
    ST_CHECK,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CELL_W-1:0]         length;
    logic [COLOUR_W-1:0]       colour;
    logic                      last;
  } run_t;

  typedef struct packed {
    logic ge;
  } sub_flags_t;

endpackage

// ===== sv/scaled_sprite_run_emitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled sprite run emitter
// Nearest-neighbour scaling of a one-bit sprite row into horizontal runs.
// ----------------------------------------------------------------------------
// A load beat stores one 32-bit sprite row (bit 31 is the leftmost column).
// A draw beat names a destination row of a square cell whose side is the
// cell_size register; the block emits one beat per run of set pixels, left to
// right, with last_run on the final one, and nothing at all when the source
// row is empty or the row lies outside the cell. A draw reads source row
// sy = row * SPRITE_SIZE / cell and takes sx = (cell - 1) * SPRITE_SIZE /
// cell, at most SPRITE_SIZE - 1, source column steps. Every division is done
// by repeated subtraction of the cell side in a single shared compare-subtract
// unit, one step per cycle. An empty source row ends the draw without a walk.
// The input side is not ready while a draw is in progress. Downstream stalls
// hold the walk only when a second finished run must leave while the output
// register is still full. Sprite rows must be loaded before they are drawn.
// ----------------------------------------------------------------------------
module scaled_sprite_run_emitter_top #(
  parameter int unsigned SPRITE_SIZE = 32,
  parameter int unsigned MAX_CELL    = 255
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: cell side.
  input  logic                                cfg_we_i,
  input  logic [ssre_pkg::CELL_W-1:0]         cfg_wdata_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [ssre_pkg::CELL_W-1:0]         row_number_i,
  input  logic [ssre_pkg::WORD_W-1:0]         mask_word_i,
  input  logic signed [ssre_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [ssre_pkg::COORD_W-1:0] origin_y_i,
  input  logic [ssre_pkg::COLOUR_W-1:0]       colour_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ssre_pkg::COORD_W-1:0] run_x_o,
  output logic signed [ssre_pkg::COORD_W-1:0] run_y_o,
  output logic [ssre_pkg::CELL_W-1:0]         run_length_o,
  output logic [ssre_pkg::COLOUR_W-1:0]       run_colour_o,
  output logic                                last_run_o
);
  import ssre_pkg::*;

  // Remainder width covers row * SPRITE_SIZE for any row inside the cell.
  localparam int unsigned RW  = $clog2(MAX_CELL * SPRITE_SIZE);
  localparam int unsigned SXW = $clog2(SPRITE_SIZE);

  state_e state_q, state_d;

  logic [CELL_W-1:0]   cell_q, cell_d;
  logic [CELL_W-1:0]   cell_eff;
  logic [RW-1:0]       rem_q, rem_d;
  logic [SXW-1:0]      idx_q, idx_d;
  logic [CELL_W-1:0]   px_q, px_d;
  logic [CELL_W-1:0]   start_q, start_d;
  logic                in_run_q, in_run_d;
  logic                have_held_q, have_held_d;
  logic [CELL_W-1:0]   held_start_q, held_start_d;
  logic [CELL_W-1:0]   held_len_q, held_len_d;
  logic [COORD_W-1:0]  ox_q, ox_d;
  logic [COORD_W-1:0]  y_q, y_d;
  logic [COLOUR_W-1:0] colour_q, colour_d;

  logic                accept;
  logic                mem_we;
  logic                mem_re;
  logic [WORD_W-1:0]   src_row;
  sub_flags_t          sub_flags;
  logic [RW-1:0]       sub_diff;
  logic [COL_W-1:0]    col;
  logic                at_end;
  logic                pix_on;
  logic                closing;
  logic                push_valid;
  logic                push_ready;
  logic                push_last;
  run_t                push_run;
  run_t                out_run;

  // Register values above the largest supported cell saturate.
  assign cell_eff = (cell_q > CELL_W'(MAX_CELL)) ? CELL_W'(MAX_CELL) : cell_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign mem_we     = accept && (kind_i == KIND_LOAD)
                      && (row_number_i < CELL_W'(SPRITE_SIZE));

  ssre_row_mem #(
    .DEPTH (SPRITE_SIZE),
    .AW    (SXW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (row_number_i[SXW-1:0]),
    .wdata_i (mask_word_i),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (src_row)
  );

  // The one divider step: subtract the cell side from the running remainder.
  ssre_sub_unit #(
    .W (RW)
  ) u_sub_unit (
    .minuend_i    (rem_q),
    .subtrahend_i (RW'(cell_eff)),
    .flags_o      (sub_flags),
    .diff_o       (sub_diff)
  );

  assign col     = LEFT_COL - COL_W'(idx_q);
  assign at_end  = (px_q == cell_eff);
  assign pix_on  = ~at_end & src_row[col];
  assign closing = ~pix_on & in_run_q;

  // The held run goes out with last set only in the flush state.
  assign push_last       = (state_q == ST_FLUSH);
  assign push_run.x      = ox_q + {{(COORD_W - CELL_W){1'b0}}, held_start_q};
  assign push_run.y      = y_q;
  assign push_run.length = held_len_q;
  assign push_run.colour = colour_q;
  assign push_run.last   = push_last;

  always_comb begin
    state_d      = state_q;
    cell_d       = cell_q;
    rem_d        = rem_q;
    idx_d        = idx_q;
    px_d         = px_q;
    start_d      = start_q;
    in_run_d     = in_run_q;
    have_held_d  = have_held_q;
    held_start_d = held_start_q;
    held_len_d   = held_len_q;
    ox_d         = ox_q;
    y_d          = y_q;
    colour_d     = colour_q;
    mem_re       = 1'b0;
    push_valid   = 1'b0;

    if (cfg_we_i) begin
      cell_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == KIND_DRAW) && (cell_eff != '0)
            && (row_number_i < cell_eff)) begin
          rem_d    = RW'(row_number_i) * RW'(SPRITE_SIZE);
          idx_d    = '0;
          ox_d     = origin_x_i;
          y_d      = origin_y_i + {{(COORD_W - CELL_W){1'b0}}, row_number_i};
          colour_d = colour_i;
          state_d  = ST_DIV_ROW;
        end
      end
      ST_DIV_ROW: begin
        // Source row is the number of times the cell fits into row * size.
        if (sub_flags.ge) begin
          rem_d = sub_diff;
          idx_d = idx_q + SXW'(1);
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_re      = 1'b1;
        rem_d       = '0;
        idx_d       = '0;
        px_d        = '0;
        in_run_d    = 1'b0;
        have_held_d = 1'b0;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = (src_row == '0) ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        if (!at_end && sub_flags.ge) begin
          // Advance the source column until the remainder drops below the cell.
          rem_d = sub_diff;
          idx_d = idx_q + SXW'(1);
        end else if (!(closing && have_held_q && !push_ready)) begin
          if (closing) begin
            push_valid   = have_held_q;
            held_start_d = start_q;
            held_len_d   = px_q - start_q;
            have_held_d  = 1'b1;
            in_run_d     = 1'b0;
          end
          if (pix_on && !in_run_q) begin
            in_run_d = 1'b1;
            start_d  = px_q;
          end
          px_d  = px_q + CELL_W'(1);
          rem_d = rem_q + RW'(SPRITE_SIZE);
          if (at_end) begin
            state_d = (have_held_q || closing) ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          have_held_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cell_q      <= CELL_RESET;
      in_run_q    <= 1'b0;
      have_held_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cell_q      <= cell_d;
      in_run_q    <= in_run_d;
      have_held_q <= have_held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    idx_q        <= idx_d;
    px_q         <= px_d;
    start_q      <= start_d;
    held_start_q <= held_start_d;
    held_len_q   <= held_len_d;
    ox_q         <= ox_d;
    y_q          <= y_d;
    colour_q     <= colour_d;
  end

  ssre_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_run_i   (push_run),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_run_o    (out_run)
  );

  assign run_x_o      = out_run.x;
  assign run_y_o      = out_run.y;
  assign run_length_o = out_run.length;
  assign run_colour_o = out_run.colour;
  assign last_run_o   = out_run.last;

endmodule

// ===== sv/ssre_row_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite row memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssre_row_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [ssre_pkg::WORD_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [ssre_pkg::WORD_W-1:0] rdata_o
);
  import ssre_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ssre_sub_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared compare and subtract unit
// Compares the running remainder against the cell side and forms the difference.
// ----------------------------------------------------------------------------
module ssre_sub_unit #(
  parameter int unsigned W = 13
) (
  input  logic [W-1:0]           minuend_i,
  input  logic [W-1:0]           subtrahend_i,
  output ssre_pkg::sub_flags_t   flags_o,
  output logic [W-1:0]           diff_o
);
  import ssre_pkg::*;

  logic [W:0] wide_diff;

  // The borrow out of the extended subtraction tells whether minuend >= subtrahend.
  assign wide_diff  = {1'b0, minuend_i} - {1'b0, subtrahend_i};
  assign flags_o.ge = ~wide_diff[W];
  assign diff_o     = wide_diff[W-1:0];

endmodule

// ===== sv/ssre_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run output register
// Holds one finished run until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module ssre_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ssre_pkg::run_t  push_run_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ssre_pkg::run_t  out_run_o
);
  import ssre_pkg::*;

  logic valid_q, valid_d;
  run_t run_q;

  assign push_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (push_valid_i && push_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      run_q <= push_run_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_run_o   = run_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled sprite run emitter testbench
// Loads sprite rows, draws scaled destination rows and checks every run beat.
// ----------------------------------------------------------------------------
// An initial block fills a queue of input beats phase by phase. A clocked
// driver offers them on the valid/ready input channel and a clocked monitor
// takes run beats off the output channel. When a beat is accepted the driver
// works out the runs it must cause from a private copy of the sprite and of
// the cell side. The monitor checks each run against the oldest of those
// expectations. Each phase uses its own cell side and one of four patterns of
// sender gaps and receiver stalls. One phase also holds the receiver off for
// a long stretch, so the block fills up and stops taking input.
// ----------------------------------------------------------------------------
module tb;
  import ssre_pkg::*;

  localparam int SPRITE_ROWS  = 32;
  // A draw can end without a single run, so every pause before a register
  // write covers a whole draw at the largest cell.
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES  = 1500;
  localparam int LIMIT_CYCLES = 2000000;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_e;

  typedef struct {
    logic                      kind;
    logic [CELL_W-1:0]         row;
    logic [WORD_W-1:0]         mask;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic [COLOUR_W-1:0]       colour;
  } sprite_beat_t;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_we_i     = 1'b0;
  logic [CELL_W-1:0]           cfg_wdata_i  = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic                        kind_i       = KIND_LOAD;
  logic [CELL_W-1:0]           row_number_i = '0;
  logic [WORD_W-1:0]           mask_word_i  = '0;
  logic signed [COORD_W-1:0]   origin_x_i   = '0;
  logic signed [COORD_W-1:0]   origin_y_i   = '0;
  logic [COLOUR_W-1:0]         colour_i     = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic signed [COORD_W-1:0]   run_x_o;
  logic signed [COORD_W-1:0]   run_y_o;
  logic [CELL_W-1:0]           run_length_o;
  logic [COLOUR_W-1:0]         run_colour_o;
  logic                        last_run_o;

  scaled_sprite_run_emitter_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .row_number_i (row_number_i),
    .mask_word_i  (mask_word_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .colour_i     (colour_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .run_x_o      (run_x_o),
    .run_y_o      (run_y_o),
    .run_length_o (run_length_o),
    .run_colour_o (run_colour_o),
    .last_run_o   (last_run_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Beats waiting to be offered, the beat on the bus, and the runs still due.
  sprite_beat_t      beats_to_send[$];
  sprite_beat_t      on_bus;
  run_t              runs_due[$];

  // Our own copy of the sprite and of the cell side register.
  logic [WORD_W-1:0] sprite_store[SPRITE_ROWS];
  logic [CELL_W-1:0] cell_reg = CELL_RESET;

  // The generator's view of which sprite rows hold data. A draw must never
  // reach a row that was not loaded, since its contents are undefined.
  bit                row_loaded[SPRITE_ROWS];

  pace_e             pace         = PACE_FREE;
  logic              hold_request = 1'b0;
  logic              hold_started = 1'b0;
  int unsigned       hold_left    = 0;
  int unsigned       mismatches   = 0;
  int unsigned       cycle_count  = 0;

  // Work out the runs that one accepted beat causes. A load only updates the
  // sprite copy. A draw picks the source row by nearest neighbour, walks the
  // destination pixels one past the cell edge so that a run touching the
  // right edge is closed, and marks the final run of the row.
  function automatic void predict_runs(input sprite_beat_t b);
    int unsigned       sy;
    int unsigned       sx;
    int unsigned       px;
    int unsigned       start;
    logic [WORD_W-1:0] src;
    bit                on;
    bit                open;
    bit                have;
    run_t              r;
    run_t              held;
    if (b.kind == KIND_LOAD) begin
      // Loads past the last sprite row are dropped by the block.
      if (b.row < SPRITE_ROWS) sprite_store[b.row] = b.mask;
      return;
    end
    // A zero cell draws nothing, and so does a row beyond the cell.
    if (cell_reg == 0 || b.row >= cell_reg) return;
    sy  = b.row * SPRITE_ROWS / cell_reg;
    src = sprite_store[sy];
    if (src == '0) return;
    open  = 1'b0;
    have  = 1'b0;
    start = 0;
    for (px = 0; px <= cell_reg; px++) begin
      on = 1'b0;
      if (px < cell_reg) begin
        sx = px * SPRITE_ROWS / cell_reg;
        on = src[LEFT_COL - sx];
      end
      if (on && !open) begin
        open  = 1'b1;
        start = px;
      end else if (!on && open) begin
        open     = 1'b0;
        // Screen coordinates wrap at 16 bits.
        r.x      = b.ox + 16'(start);
        r.y      = b.oy + 16'(b.row);
        r.length = 8'(px - start);
        r.colour = b.colour;
        r.last   = 1'b0;
        if (have) runs_due.push_back(held);
        held = r;
        have = 1'b1;
      end
    end
    if (have) begin
      held.last = 1'b1;
      runs_due.push_back(held);
    end
  endfunction

  function automatic void push_load(input logic [CELL_W-1:0] row,
                                    input logic [WORD_W-1:0] mask);
    sprite_beat_t b;
    b.kind   = KIND_LOAD;
    b.row    = row;
    b.mask   = mask;
    // Origin and colour mean nothing to a load; they carry noise.
    b.ox     = $urandom;
    b.oy     = $urandom;
    b.colour = $urandom;
    if (row < SPRITE_ROWS) row_loaded[row] = 1'b1;
    beats_to_send.push_back(b);
  endfunction

  function automatic void push_draw(input logic [CELL_W-1:0] row,
                                    input logic [COORD_W-1:0] ox,
                                    input logic [COORD_W-1:0] oy,
                                    input logic [COLOUR_W-1:0] colour);
    sprite_beat_t b;
    b.kind   = KIND_DRAW;
    b.row    = row;
    b.mask   = $urandom;
    b.ox     = ox;
    b.oy     = oy;
    b.colour = colour;
    beats_to_send.push_back(b);
  endfunction

  function automatic logic [WORD_W-1:0] pick_mask();
    case ($urandom_range(6))
      0, 1: pick_mask = $urandom;
      2:    pick_mask = $urandom & $urandom & $urandom;
      3:    pick_mask = $urandom_range(1) ? 32'hAAAA_AAAA : 32'h5555_5555;
      4:    pick_mask = 32'h1 << $urandom_range(31);
      5:    pick_mask = '1;
      default: pick_mask = '0;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_origin();
    // Keep a good share close to the wrap points.
    case ($urandom_range(3))
      0:       pick_origin = 16'h7FF0 + 16'($urandom_range(15));
      1:       pick_origin = 16'h8000 + 16'($urandom_range(15));
      default: pick_origin = $urandom;
    endcase
  endfunction

  // Mostly loads followed by draws of rows inside the cell, with some loads
  // past the sprite and some draws past the cell as noise. A draw whose
  // source row is not yet loaded gets a load of that row first.
  function automatic void queue_random_beats(input int unsigned count);
    int unsigned       n;
    int unsigned       sy;
    logic [CELL_W-1:0] row;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(9) == 0) begin
          push_load(8'($urandom_range(255, SPRITE_ROWS)), $urandom);
        end else begin
          push_load(8'($urandom_range(SPRITE_ROWS - 1)), pick_mask());
          n++;
        end
      end else begin
        if (cell_reg == 0) begin
          row = $urandom;
        end else if ($urandom_range(99) < 88) begin
          row = $urandom_range(cell_reg - 1);
          n++;
        end else begin
          row = $urandom_range(255, cell_reg);
        end
        if (cell_reg != 0 && row < cell_reg) begin
          sy = row * SPRITE_ROWS / cell_reg;
          if (!row_loaded[sy]) begin
            push_load(8'(sy), pick_mask());
            n++;
          end
        end
        push_draw(row, pick_origin(), pick_origin(), $urandom);
      end
    end
  endfunction

  // Driver: offers the next beat whenever the bus is free and the sender is
  // not taking a gap. The expected runs are worked out at acceptance, with
  // the cell side that is in force then.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      case (pace)
        PACE_SENDER_IDLE: gap_pct = 72;
        PACE_BOTH:        gap_pct = 12;
        default:          gap_pct = 0;
      endcase
      if (in_valid_i && in_ready_o) predict_runs(on_bus);
      if (!in_valid_i || in_ready_o) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
          on_bus = beats_to_send.pop_front();
          kind_i       <= on_bus.kind;
          row_number_i <= on_bus.row;
          mask_word_i  <= on_bus.mask;
          origin_x_i   <= on_bus.ox;
          origin_y_i   <= on_bus.oy;
          colour_i     <= on_bus.colour;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus and counted down here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      hold_started <= 1'b0;
    end else if (hold_request && !hold_started) begin
      hold_left    <= HOLD_CYCLES;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: takes run beats and checks them against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall_pct;
    run_t        want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      case (pace)
        PACE_RECEIVER_STALL: stall_pct = 72;
        PACE_BOTH:           stall_pct = 12;
        default:             stall_pct = 0;
      endcase
      if (out_valid_o && out_ready_i) begin
        if (runs_due.size() == 0) begin
          $display("%0t: run beat with none expected, got x %0h y %0h len %0d",
                   $time, run_x_o, run_y_o, run_length_o);
          mismatches++;
        end else begin
          want = runs_due.pop_front();
          check_field("run_x", 32'(want.x), 32'(run_x_o));
          check_field("run_y", 32'(want.y), 32'(run_y_o));
          check_field("run_length", 32'(want.length), 32'(run_length_o));
          check_field("run_colour", 32'(want.colour), 32'(run_colour_o));
          check_field("last_run", 32'(want.last), 32'(last_run_o));
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Wait until every beat is taken and every run has come back, then give a
  // draw that ends without runs the time to finish. The queues and the bus
  // are looked at on the falling edge, where they are settled.
  task automatic settle();
    while (beats_to_send.size() != 0 || in_valid_i || runs_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cell(input logic [CELL_W-1:0] side);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= side;
    cell_reg = side;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CELL_W-1:0] side, input pace_e p,
                           input int unsigned count, input bit with_hold);
    write_cell(side);
    pace <= p;
    if (with_hold) hold_request <= 1'b1;
    queue_random_beats(count);
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset cell side of 26. Destination rows 1, 2, 3
    // and 25 map to source rows 1, 2, 3 and 30.
    push_load(8'd0, 32'hFFFF_FFFF);
    push_load(8'd1, 32'h0000_0000);
    push_load(8'd2, 32'h8000_0001);
    push_load(8'd3, 32'h5555_5555);
    push_load(8'd30, 32'hAAAA_AAAA);
    push_load(8'd32, 32'hFFFF_FFFF);
    push_load(8'd255, 32'hFFFF_FFFF);
    // A full row that starts at the top of the signed range.
    push_draw(8'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    // An empty source row gives no runs.
    push_draw(8'd1, 16'h0010, 16'h0020, 16'h1234);
    // Only the outermost columns are set.
    push_draw(8'd2, 16'h8000, 16'h8000, 16'h0000);
    push_draw(8'd3, 16'hFFFF, 16'h0000, 16'hF800);
    push_draw(8'd25, 16'h0100, 16'hFFF0, 16'h07E0);
    // Rows at and past the cell edge give nothing.
    push_draw(8'd26, 16'h0000, 16'h0000, 16'h001F);
    push_draw(8'd255, 16'h7FFF, 16'h8000, 16'hAAAA);
    settle();

    run_phase(8'd32, PACE_FREE, 60, 1'b1);
    run_phase(8'd1, PACE_SENDER_IDLE, 50, 1'b0);
    run_phase(8'd255, PACE_RECEIVER_STALL, 30, 1'b0);
    run_phase(8'd7, PACE_BOTH, 60, 1'b0);
    run_phase(8'd0, PACE_FREE, 5, 1'b0);
    run_phase(8'd100, PACE_RECEIVER_STALL, 50, 1'b0);
    run_phase(8'd16, PACE_BOTH, 50, 1'b0);
    run_phase(8'd48, PACE_SENDER_IDLE, 60, 1'b0);
    run_phase(CELL_RESET, PACE_FREE, 40, 1'b0);

    if (mismatches == 0 && runs_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== scaled_sprite_run_emitter_top.f =====
sv/ssre_pkg.sv
sv/ssre_row_mem.sv
sv/ssre_sub_unit.sv
sv/ssre_out_reg.sv
sv/scaled_sprite_run_emitter_top.sv
tb/tb.sv
